>>> rtl/frc_pkg.sv
// Shared types and constants for the firmware record checker.
// No dependencies.
package frc_pkg;

  localparam logic [1:0] CFG_UPLOAD = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_RAM    = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_WRAP    = 2'd2,
    ST_BIG     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_OFFSET = 2'd0,
    PH_COUNT  = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef struct packed {
    logic        upload;
    logic [31:0] length;
    logic [32:0] ram;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] data;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

>>> rtl/frc_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on frc_pkg.
module frc_result_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frc_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output frc_pkg::result_t head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  frc_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rp_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign wp1         = ptr_next(wp_q);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = pop ? ptr_next(rp_q) : rp_q;
    cnt_d = cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);
    if (push_i.push0 && push_i.push1) begin
      wp_d = ptr_next(wp1);
    end else if (push_i.push0) begin
      wp_d = wp1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wp_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wp1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/frc_parser.sv
// Input register, record parser state and header checks; emits results.
// Depends on frc_pkg.
module frc_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  logic [7:0]     byte_value_i,
  input  frc_pkg::cfg_t  cfg_i,
  input  logic           room_i,
  output frc_pkg::push_t push_o
);

  logic               s1_valid_q, s1_valid_d;
  logic               s1_type_q;
  logic [7:0]         s1_byte_q;
  logic               advance;

  logic               active_q, active_d;
  frc_pkg::phase_e    phase_q, phase_d;
  logic [1:0]         bif_q, bif_d;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        off_q, off_d;
  logic [31:0]        wl_q, wl_d;
  logic [31:0]        aw_q, aw_d;

  logic [31:0]        aw_new, pos_n;
  logic [32:0]        rem_n;
  logic [33:0]        span;
  frc_pkg::status_e   hdr_st, end_st;
  logic               wr, fail, fin;
  frc_pkg::result_t   wr_res, st_res;

  assign advance    = s1_valid_q && room_i;
  assign in_ready_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // byte assembly and header checks
  // rem_n[32] set: length now below the stream position, remaining counts as unbounded
  assign aw_new = (bif_q == 2'd0) ? {24'd0, s1_byte_q}
                                  : aw_q | ({24'd0, s1_byte_q} << {bif_q, 3'b000});
  assign pos_n  = pos_q + 32'd1;
  assign rem_n  = {1'b0, cfg_i.length} - {1'b0, pos_n};
  assign span   = {2'b00, off_q} + {aw_new, 2'b00};

  always_comb begin
    if ((!rem_n[32] && aw_new > {2'b00, rem_n[31:2]}) || off_q[1:0] != 2'b00) begin
      hdr_st = frc_pkg::ST_INVALID;
    end else if (span[33:32] != 2'b00) begin
      hdr_st = frc_pkg::ST_WRAP;
    end else if (span > {1'b0, cfg_i.ram}) begin
      hdr_st = frc_pkg::ST_BIG;
    end else begin
      hdr_st = frc_pkg::ST_OK;
    end
  end

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    bif_d    = bif_q;
    pos_d    = pos_q;
    off_d    = off_q;
    wl_d     = wl_q;
    aw_d     = aw_q;
    wr       = 1'b0;
    fail     = 1'b0;
    fin      = 1'b0;
    end_st   = frc_pkg::ST_OK;
    if (advance) begin
      if (s1_type_q == frc_pkg::REQ_START) begin
        active_d = (cfg_i.length != 32'd0);
        phase_d  = frc_pkg::PH_OFFSET;
        bif_d    = 2'd0;
        pos_d    = '0;
        off_d    = '0;
        wl_d     = '0;
        aw_d     = '0;
        fin      = (cfg_i.length == 32'd0);
        end_st   = frc_pkg::ST_INVALID;
      end else if (active_q) begin
        aw_d  = aw_new;
        bif_d = bif_q + 2'd1;
        pos_d = pos_n;
        if (bif_q == 2'd3) begin
          case (phase_q)
            frc_pkg::PH_OFFSET: begin
              off_d   = aw_new;
              phase_d = frc_pkg::PH_COUNT;
            end
            frc_pkg::PH_COUNT: begin
              wl_d = aw_new;
              if (hdr_st != frc_pkg::ST_OK) begin
                fail = 1'b1;
              end else begin
                phase_d = (aw_new == 32'd0) ? frc_pkg::PH_OFFSET : frc_pkg::PH_DATA;
              end
            end
            frc_pkg::PH_DATA: begin
              wr    = cfg_i.upload;
              off_d = off_q + 32'd4;
              wl_d  = wl_q - 32'd1;
              if (wl_q == 32'd1) begin
                phase_d = frc_pkg::PH_OFFSET;
              end
            end
            default: ;
          endcase
        end
        if (fail) begin
          active_d = 1'b0;
          fin      = 1'b1;
          end_st   = hdr_st;
        end else if (pos_n == cfg_i.length) begin
          active_d = 1'b0;
          fin      = 1'b1;
          end_st   = (phase_d == frc_pkg::PH_OFFSET && bif_d == 2'd0) ? frc_pkg::ST_OK
                                                                      : frc_pkg::ST_INVALID;
        end
      end
    end
  end

  always_comb begin
    wr_res        = '0;
    wr_res.kind   = frc_pkg::KIND_WRITE;
    wr_res.addr   = off_q;
    wr_res.data   = aw_new;
    wr_res.status = frc_pkg::ST_OK;
    wr_res.last   = !fin;
    st_res        = '0;
    st_res.kind   = frc_pkg::KIND_STATUS;
    st_res.status = end_st;
    st_res.last   = 1'b1;
    push_o        = '0;
    push_o.push0  = wr || fin;
    push_o.push1  = wr && fin;
    push_o.res0   = wr ? wr_res : st_res;
    push_o.res1   = st_res;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_type_q <= req_type_i;
      s1_byte_q <= byte_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      active_q   <= 1'b0;
      phase_q    <= frc_pkg::PH_OFFSET;
      bif_q      <= '0;
      pos_q      <= '0;
      off_q      <= '0;
      wl_q       <= '0;
      aw_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      active_q   <= active_d;
      phase_q    <= phase_d;
      bif_q      <= bif_d;
      pos_q      <= pos_d;
      off_q      <= off_d;
      wl_q       <= wl_d;
      aw_q       <= aw_d;
    end
  end

endmodule

>>> rtl/firmware_record_checker.sv
// Top level of the firmware record checker: config registers, parser, result queue.
// Depends on frc_pkg, frc_parser, frc_result_fifo.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o | req_type_i, byte_value_i
//  out     | out_valid_o/out_ready_i | result_kind_o, write_address_o, write_data_o,
//          |                         | status_code_o, last_result_o
//  cfg     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One item per cycle while the queue has room; results pass input register and queue.
// The input register hands an item on when the result queue has room for two results.
// Reset clears parser state and queue pointers; config registers reset to zero.
// A stalled output only backs up the input once the queue has fewer than two free entries.
module firmware_record_checker #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic [1:0]  status_code_o,
  output logic        last_result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [32:0] cfg_wdata_i
);

  frc_pkg::cfg_t    cfg_q, cfg_d;
  frc_pkg::push_t   push;
  frc_pkg::result_t head;
  logic             room;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        frc_pkg::CFG_UPLOAD: cfg_d.upload = cfg_wdata_i[0];
        frc_pkg::CFG_LENGTH: cfg_d.length = cfg_wdata_i[31:0];
        frc_pkg::CFG_RAM:    cfg_d.ram    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  frc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .byte_value_i (byte_value_i),
    .cfg_i        (cfg_q),
    .room_i       (room),
    .push_o       (push)
  );

  frc_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign result_kind_o   = head.kind;
  assign write_address_o = head.addr;
  assign write_data_o    = head.data;
  assign status_code_o   = head.status;
  assign last_result_o   = head.last;

endmodule

>>> rtl/frc_checker.sv
// Port-level assertions for the firmware record checker, bound to the top level.
// Depends on frc_pkg and firmware_record_checker.
module frc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic [31:0] write_address_o,
  input logic [31:0] write_data_o,
  input logic [1:0]  status_code_o,
  input logic        last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_data_o)
      && $stable(write_address_o) && $stable(status_code_o))
    else $error("output changed while stalled");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == frc_pkg::KIND_STATUS |->
      write_address_o == 32'd0 && write_data_o == 32'd0 && last_result_o)
    else $error("status result carries write payload or is not last");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == frc_pkg::KIND_WRITE |->
      write_address_o[1:0] == 2'b00 && status_code_o == frc_pkg::ST_OK)
    else $error("write result misaligned or carries status");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && result_kind_o == frc_pkg::KIND_WRITE && !last_result_o
      |=> out_valid_o && result_kind_o == frc_pkg::KIND_STATUS)
    else $error("write not followed by its status");

endmodule

bind firmware_record_checker frc_checker u_frc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_o   (result_kind_o),
  .write_address_o (write_address_o),
  .write_data_o    (write_data_o),
  .status_code_o   (status_code_o),
  .last_result_o   (last_result_o)
);
